// ===== hw/rtl/stc_pkg.sv =====
// shared constants and types for the seconds-to-calendar converter
// field widths, reciprocal multipliers for constant divisors, stage control struct
// no dependencies
package stc_pkg;

  // field widths
  localparam int SECS_W   = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int WDAY_W   = 3;

  // pipeline depth
  localparam int NUM_STAGES = 8;

  // calendar constants
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned JDN_EPOCH     = 2440588;
  localparam int unsigned JDN_OFFSET    = 32044;
  localparam int unsigned DAYS_400Y     = 146097;
  localparam int unsigned DAYS_4Y       = 1461;
  localparam int unsigned MONTH_SPAN    = 153;
  localparam int unsigned YEAR_BASE     = 4800;
  localparam int unsigned WEEK_LEN      = 7;
  localparam int unsigned MONTH_WRAP    = 10;
  localparam int unsigned MONTHS        = 12;

  // day number of the epoch offset into the first date step
  localparam int unsigned DATE_BASE = JDN_EPOCH + JDN_OFFSET;
  // weekday of the epoch, jdn mod 7
  localparam int unsigned WDAY_BASE = JDN_EPOCH % WEEK_LEN;

  // seconds per day is 2^7 * 675: shift first, then reciprocal multiply
  localparam int DAY_SHIFT = 7;
  localparam int unsigned DAY_ODD = SECS_PER_DAY >> DAY_SHIFT;

  // reciprocal shifts: dividend bits plus ceil(log2(divisor))
  localparam int DAY_K    = 35;  // 25-bit dividend, /675
  localparam int CENT_K   = 42;  // 24-bit dividend, /146097
  localparam int WEEK_K   = 20;  // 17-bit dividend, /7
  localparam int HOUR_K   = 29;  // 17-bit dividend, /3600
  localparam int QUAD_K   = 29;  // 18-bit dividend, /1461
  localparam int MIN_K    = 18;  // 12-bit dividend, /60
  localparam int MSPAN_K  = 19;  // 11-bit dividend, /153
  localparam int FIVE_K   = 14;  // 11-bit dividend, /5

  // reciprocals, rounded up
  localparam logic [25:0] DAY_RECIP =
    26'(((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
  localparam logic [24:0] CENT_RECIP =
    25'(((64'd1 << CENT_K) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
  localparam logic [17:0] WEEK_RECIP =
    18'(((64'd1 << WEEK_K) + 64'(WEEK_LEN) - 64'd1) / 64'(WEEK_LEN));
  localparam logic [17:0] HOUR_RECIP =
    18'(((64'd1 << HOUR_K) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
  localparam logic [18:0] QUAD_RECIP =
    19'(((64'd1 << QUAD_K) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));
  localparam logic [12:0] MIN_RECIP =
    13'(((64'd1 << MIN_K) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
  localparam logic [11:0] MSPAN_RECIP =
    12'(((64'd1 << MSPAN_K) + 64'(MONTH_SPAN) - 64'd1) / 64'(MONTH_SPAN));
  localparam logic [11:0] FIVE_RECIP =
    12'(((64'd1 << FIVE_K) + 64'd4) / 64'd5);

  // per-stage load enables and valid flags
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } stc_ctl_t;

endpackage

// ===== hw/rtl/seconds_to_calendar_unit.sv =====
// seconds-to-calendar converter: epoch seconds to civil date, time of day and weekday
// throughput: one item per cycle while date_stall is low
// eight register stages, each with at most one constant-reciprocal multiply per path
// a stall at the output holds each full stage with no empty stage after it; empty stages still fill
// reset (rst, synchronous) clears the stage valid bits only; data registers are not reset
// depends on stc_pkg and stc_ctl
module seconds_to_calendar_unit
  import stc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                epoch_valid,
  output logic                epoch_stall,
  input  logic [SECS_W-1:0]   epoch_seconds,
  output logic                date_valid,
  input  logic                date_stall,
  output logic [YEAR_W-1:0]   year,
  output logic [MONTH_W-1:0]  month,
  output logic [DAY_W-1:0]    day,
  output logic [HOUR_W-1:0]   hour,
  output logic [MINUTE_W-1:0] minute,
  output logic [SECOND_W-1:0] second,
  output logic [WDAY_W-1:0]   weekday
);

  stc_ctl_t ctl;

  stc_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .epoch_valid (epoch_valid),
    .epoch_stall (epoch_stall),
    .date_stall  (date_stall),
    .ctl         (ctl)
  );

  assign date_valid = ctl.valid[NUM_STAGES-1];

  // stage 0: day count by reciprocal of 675 after dropping 7 low bits
  logic [50:0]       p0;
  logic [SECS_W-1:0] s0_secs;
  logic [15:0]       s0_days;

  assign p0 = 51'(epoch_seconds[SECS_W-1:DAY_SHIFT]) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s0_secs <= epoch_seconds;
      s0_days <= 16'(p0 >> DAY_K);
    end
  end

  // stage 1: time of day, century count, weekday quotient
  logic [21:0] a1;
  logic [23:0] x1;
  logic [48:0] p1b;
  logic [16:0] w1;
  logic [34:0] p1w;
  logic [16:0] s1_tod;
  logic [21:0] s1_a;
  logic [6:0]  s1_b;
  logic [16:0] s1_wsum;
  logic [14:0] s1_wq;

  assign a1  = 22'(s0_days) + 22'(DATE_BASE);
  assign x1  = {a1, 2'b11};
  assign p1b = 49'(x1) * 49'(CENT_RECIP);
  assign w1  = 17'(s0_days) + 17'(WDAY_BASE);
  assign p1w = 35'(w1) * 35'(WEEK_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s1_tod  <= 17'(s0_secs - 32'(s0_days) * 32'(SECS_PER_DAY));
      s1_a    <= a1;
      s1_b    <= 7'(p1b >> CENT_K);
      s1_wsum <= w1;
      s1_wq   <= 15'(p1w >> WEEK_K);
    end
  end

  // stage 2: day within the 400-year cycle, hour, weekday remainder
  logic [24:0] cent2;
  logic [34:0] p2h;
  logic [15:0] s2_a2;
  logic [6:0]  s2_b;
  logic [16:0] s2_tod;
  logic [HOUR_W-1:0] s2_hour;
  logic [WDAY_W-1:0] s2_wday;

  assign cent2 = 25'(s1_b) * 25'(DAYS_400Y);
  assign p2h   = 35'(s1_tod) * 35'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s2_a2   <= 16'(25'(s1_a) - (cent2 >> 2));
      s2_b    <= s1_b;
      s2_tod  <= s1_tod;
      s2_hour <= HOUR_W'(p2h >> HOUR_K);
      s2_wday <= WDAY_W'(s1_wsum - 17'(s1_wq) * 17'(WEEK_LEN));
    end
  end

  // stage 3: four-year cycle count, seconds within the hour
  logic [17:0] x3;
  logic [36:0] p3c;
  logic [15:0] s3_a2;
  logic [6:0]  s3_b;
  logic [6:0]  s3_c;
  logic [11:0] s3_rem;
  logic [HOUR_W-1:0] s3_hour;
  logic [WDAY_W-1:0] s3_wday;

  assign x3  = {s2_a2, 2'b11};
  assign p3c = 37'(x3) * 37'(QUAD_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s3_a2   <= s2_a2;
      s3_b    <= s2_b;
      s3_c    <= 7'(p3c >> QUAD_K);
      s3_rem  <= 12'(s2_tod - 17'(s2_hour) * 17'(SECS_PER_HOUR));
      s3_hour <= s2_hour;
      s3_wday <= s2_wday;
    end
  end

  // stage 4: day of the year (march based), minute
  logic [17:0] quad4;
  logic [24:0] p4m;
  logic [8:0]  s4_a3;
  logic [6:0]  s4_b;
  logic [6:0]  s4_c;
  logic [11:0] s4_rem;
  logic [MINUTE_W-1:0] s4_minute;
  logic [HOUR_W-1:0]   s4_hour;
  logic [WDAY_W-1:0]   s4_wday;

  assign quad4 = 18'(s3_c) * 18'(DAYS_4Y);
  assign p4m   = 25'(s3_rem) * 25'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s4_a3     <= 9'(18'(s3_a2) - (quad4 >> 2));
      s4_b      <= s3_b;
      s4_c      <= s3_c;
      s4_rem    <= s3_rem;
      s4_minute <= MINUTE_W'(p4m >> MIN_K);
      s4_hour   <= s3_hour;
      s4_wday   <= s3_wday;
    end
  end

  // stage 5: month index from march, second
  logic [10:0] x5;
  logic [22:0] p5d;
  logic [8:0]  s5_a3;
  logic [6:0]  s5_b;
  logic [6:0]  s5_c;
  logic [3:0]  s5_d;
  logic [MINUTE_W-1:0] s5_minute;
  logic [SECOND_W-1:0] s5_second;
  logic [HOUR_W-1:0]   s5_hour;
  logic [WDAY_W-1:0]   s5_wday;

  assign x5  = 11'(s4_a3) * 11'd5 + 11'd2;
  assign p5d = 23'(x5) * 23'(MSPAN_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      s5_a3     <= s4_a3;
      s5_b      <= s4_b;
      s5_c      <= s4_c;
      s5_d      <= 4'(p5d >> MSPAN_K);
      s5_minute <= s4_minute;
      s5_second <= SECOND_W'(s4_rem - 12'(s4_minute) * 12'(SECS_PER_MIN));
      s5_hour   <= s4_hour;
      s5_wday   <= s4_wday;
    end
  end

  // stage 6: year and month, days before the month (times five)
  logic        wrap6;
  logic [13:0] yr6;
  logic [8:0]  s6_a3;
  logic [10:0] s6_e;
  logic [YEAR_W-1:0]   s6_year;
  logic [MONTH_W-1:0]  s6_month;
  logic [MINUTE_W-1:0] s6_minute;
  logic [SECOND_W-1:0] s6_second;
  logic [HOUR_W-1:0]   s6_hour;
  logic [WDAY_W-1:0]   s6_wday;

  // march-based months ten and eleven fall in the next year
  assign wrap6 = (s5_d >= 4'(MONTH_WRAP));
  assign yr6   = 14'(s5_b) * 14'd100 + 14'(s5_c) + 14'(wrap6) - 14'(YEAR_BASE);

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      s6_a3     <= s5_a3;
      s6_e      <= 11'(s5_d) * 11'(MONTH_SPAN) + 11'd2;
      s6_year   <= YEAR_W'(yr6);
      s6_month  <= wrap6 ? MONTH_W'(s5_d + 4'd3 - 4'(MONTHS)) : MONTH_W'(s5_d + 4'd3);
      s6_minute <= s5_minute;
      s6_second <= s5_second;
      s6_hour   <= s5_hour;
      s6_wday   <= s5_wday;
    end
  end

  // stage 7: day of month, output registers
  logic [22:0] p7;
  logic [8:0]  q7;

  assign p7 = 23'(s6_e) * 23'(FIVE_RECIP);
  assign q7 = 9'(p7 >> FIVE_K);

  always_ff @(posedge clk) begin
    if (ctl.load[7]) begin
      year    <= s6_year;
      month   <= s6_month;
      day     <= DAY_W'(s6_a3 - q7 + 9'd1);
      hour    <= s6_hour;
      minute  <= s6_minute;
      second  <= s6_second;
      weekday <= s6_wday;
    end
  end

endmodule

// ===== hw/rtl/stc_ctl.sv =====
// stage control for the converter pipeline: valid bits and stall propagation
// a stage loads when it is empty or its successor loads, so bubbles collapse
// depends on stc_pkg
module stc_ctl
  import stc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     epoch_valid,
  output logic     epoch_stall,
  input  logic     date_stall,
  output stc_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;
  logic [NUM_STAGES:0]   ready;

  // ready ripples back from the output side
  always_comb begin
    ready[NUM_STAGES] = !date_stall;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  // each stage takes its predecessor's valid when it loads
  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (ready[i]) begin
        valid_next[i] = (i == 0) ? epoch_valid : valid[(i == 0) ? 0 : i - 1];
      end else begin
        valid_next[i] = valid[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign epoch_stall = !ready[0];
  assign ctl.load    = ready[NUM_STAGES-1:0];
  assign ctl.valid   = valid;

endmodule
